// File: rtl/core/hc_pkg.sv
// ============================================================================
// hc_pkg
// Shared types, constants and bit-placement functions of the Hamming codec.
// ============================================================================
package hc_pkg;

    localparam int C_WORD_W      = 63;
    localparam int C_LEN_W       = 6;
    localparam int C_MAX_DATA_BITS = 57;
    localparam logic [C_LEN_W-1:0] C_DATA_LEN_RST = C_LEN_W'(4);

    typedef logic [C_WORD_W-1:0] t_word;
    typedef logic [C_LEN_W-1:0]  t_len;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    // Clamp data length to 1..C_MAX_DATA_BITS.
    function automatic t_len sat_len(input t_len k);
        t_len res;
        res = k;
        if (k == '0) begin
            res = C_LEN_W'(1);
        end else if (k > C_LEN_W'(C_MAX_DATA_BITS)) begin
            res = C_LEN_W'(C_MAX_DATA_BITS);
        end
        return res;
    endfunction

    // Codeword length k + r, smallest r with 2^r >= k + r + 1.
    function automatic t_len cw_len(input t_len k);
        logic [7:0] r;
        logic [7:0] pw;
        r  = '0;
        pw = 8'd1;
        for (int i = 0; i < 7; i++) begin
            if (pw < ({2'b00, k} + r + 8'd1)) begin
                r  = r + 8'd1;
                pw = {pw[6:0], 1'b0};
            end
        end
        return C_LEN_W'({2'b00, k} + r);
    endfunction

    // Data bit j goes to the j-th position that is not a power of two.
    function automatic t_word scatter(input t_word d);
        t_word res;
        int    j;
        res = '0;
        j   = 0;
        for (int p = 1; p <= C_WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                res[p-1] = d[j];
                j        = j + 1;
            end
        end
        return res;
    endfunction

    // XOR of the positions of all set bits.
    function automatic t_len syndrome(input t_word cw);
        t_len s;
        s = '0;
        for (int p = 1; p <= C_WORD_W; p++) begin
            if (cw[p-1]) begin
                s = s ^ C_LEN_W'(p);
            end
        end
        return s;
    endfunction

    // Bit p-1 set for every position p <= n.
    function automatic t_word len_mask(input t_len n);
        t_word res;
        for (int p = 1; p <= C_WORD_W; p++) begin
            res[p-1] = (C_LEN_W'(p) <= n);
        end
        return res;
    endfunction

    // One-hot at position s (none when s is 0).
    function automatic t_word pos_hot(input t_len s);
        t_word res;
        for (int p = 1; p <= C_WORD_W; p++) begin
            res[p-1] = (s == C_LEN_W'(p));
        end
        return res;
    endfunction

endpackage

// File: rtl/core/hamming_codec_unit.sv
// ============================================================================
// hamming_codec_unit
// Single-error-correcting Hamming encoder/decoder with configurable data length.
// Stages: input register -> XOR trees -> result register (2 register stages).
// Throughput: one word per cycle unless the output stalls.
// Reset: synchronous active low; pipeline emptied, data length set to 4.
// ============================================================================
module hamming_codec_unit
    import hc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [C_LEN_W-1:0] i_cfg_data_length,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [C_WORD_W-1:0] i_word_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [C_WORD_W-1:0] o_word_out,
    output logic               o_error_found,
    output logic [C_LEN_W-1:0] o_error_position,
    output logic               o_uncorrectable
);

    t_len  r_n;
    logic  r_s1_valid;
    t_op   r_s1_op;
    t_word r_s1_word;
    logic  r_out_valid;
    t_word r_word_out;
    logic  r_found;
    t_len  r_pos;
    logic  r_bad;

    logic  adv;
    t_word mask;
    t_word enc_data;
    t_len  enc_syn;
    t_word enc_word;
    t_word dec_cw;
    t_len  dec_syn;
    logic  dec_bad;
    t_word n_word_out;
    logic  n_found;
    t_len  n_pos;
    logic  n_bad;

    assign o_cfg_ready = 1'b1;
    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= cw_len(C_DATA_LEN_RST);
        end else if (i_cfg_valid) begin
            r_n <= cw_len(sat_len(i_cfg_data_length));
        end
    end

    always_comb begin
        mask     = len_mask(r_n);
        enc_data = scatter(r_s1_word) & mask;
        enc_syn  = syndrome(enc_data);
        enc_word = enc_data;
        for (int i = 0; i < C_LEN_W; i++) begin
            enc_word[(1 << i) - 1] = enc_syn[i];
        end
        dec_cw  = r_s1_word & mask;
        dec_syn = syndrome(dec_cw);
        dec_bad = (dec_syn > r_n);
        if (r_s1_op == OP_DECODE) begin
            n_word_out = dec_bad ? dec_cw : (dec_cw ^ pos_hot(dec_syn));
            n_found    = (dec_syn != '0);
            n_pos      = dec_syn;
            n_bad      = dec_bad;
        end else begin
            n_word_out = enc_word;
            n_found    = 1'b0;
            n_pos      = '0;
            n_bad      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_op   <= t_op'(i_operation);
            r_s1_word <= i_word_in;
        end
        if (adv && r_s1_valid) begin
            r_word_out <= n_word_out;
            r_found    <= n_found;
            r_pos      <= n_pos;
            r_bad      <= n_bad;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_word_out       = r_word_out;
    assign o_error_found    = r_found;
    assign o_error_position = r_pos;
    assign o_uncorrectable  = r_bad;

`ifndef SYNTHESIS
    a_bad_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_uncorrectable) |-> o_error_found)
        else $error("uncorrectable without error_found");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_error_found) |-> (o_error_position == '0 && !o_uncorrectable))
        else $error("position reported without error");

    a_cw_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n >= C_LEN_W'(3))
        else $error("codeword length out of range");

    a_adv_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv) |=> o_out_valid)
        else $error("stage 1 word lost");
`endif

endmodule

// File: tb/sv/hamming_codec_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// hamming_codec_unit_tb
// Self-checking bench for the Hamming SEC codec. Words are pushed through
// both handshakes with random gaps, a long output hold and a burst phase.
// Each accepted word is predicted and the result checked field by field.
// ============================================================================
module hamming_codec_unit_tb
    import hc_pkg::*;
;

    localparam int C_CYCLE_LIMIT = 200000;
    localparam int C_WORDS_PER_PHASE = 40;
    localparam int C_IDLE_PCT = 37;

    typedef struct packed {
        t_word word;
        logic  found;
        t_len  pos;
        logic  bad;
    } t_hc_result;

    class hc_scoreboard;
        t_len       data_len;
        t_hc_result expected_q[$];
        int         mismatches;
        int         words_in;

        function new();
            data_len   = C_DATA_LEN_RST;
            mismatches = 0;
            words_in   = 0;
        endfunction

        function int code_len();
            int k;
            int r;
            k = data_len;
            if (k < 1) k = 1;
            if (k > C_MAX_DATA_BITS) k = C_MAX_DATA_BITS;
            r = 0;
            while ((1 << r) < k + r + 1) r++;
            return k + r;
        endfunction

        function t_hc_result predict(t_op op, t_word w);
            t_hc_result res;
            int         n;
            int         j;
            int         syn;
            n   = code_len();
            res = '0;
            syn = 0;
            if (op == OP_ENCODE) begin
                j = 0;
                for (int p = 1; p <= n; p++) begin
                    if ((p & (p - 1)) != 0) begin
                        res.word[p-1] = w[j];
                        if (w[j]) syn ^= p;
                        j++;
                    end
                end
                for (int i = 0; (1 << i) <= n; i++) begin
                    res.word[(1 << i) - 1] = syn[i];
                end
            end else begin
                for (int p = 1; p <= n; p++) begin
                    res.word[p-1] = w[p-1];
                    if (w[p-1]) syn ^= p;
                end
                if (syn != 0) begin
                    res.found = 1'b1;
                    res.pos   = t_len'(syn);
                    if (syn <= n) begin
                        res.word[syn-1] = ~res.word[syn-1];
                    end else begin
                        res.bad = 1'b1;
                    end
                end
            end
            return res;
        endfunction

        function void note_word(t_op op, t_word w);
            expected_q.push_back(predict(op, w));
            words_in++;
        endfunction

        function void flag(string field, t_word exp_v, t_word act_v);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH %s: expected %0h, got %0h", field, exp_v, act_v);
            end
        endfunction

        function void check_word(t_hc_result got);
            t_hc_result exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH unexpected result word %0h", got.word);
                end
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.word !== exp_r.word) flag("word_out", exp_r.word, got.word);
            if (got.found !== exp_r.found) begin
                flag("error_found", t_word'(exp_r.found), t_word'(got.found));
            end
            if (got.pos !== exp_r.pos) begin
                flag("error_position", t_word'(exp_r.pos), t_word'(got.pos));
            end
            if (got.bad !== exp_r.bad) begin
                flag("uncorrectable", t_word'(exp_r.bad), t_word'(got.bad));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [C_LEN_W-1:0] i_cfg_data_length = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_operation = 1'b0;
    t_word              i_word_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_word              o_word_out;
    logic               o_error_found;
    t_len               o_error_position;
    logic               o_uncorrectable;

    hc_scoreboard sb = new();
    int           cycles = 0;
    logic         burst = 1'b0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;

    hamming_codec_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data_length (i_cfg_data_length),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_word_in         (i_word_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_word_out        (o_word_out),
        .o_error_found     (o_error_found),
        .o_error_position  (o_error_position),
        .o_uncorrectable   (o_uncorrectable)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == C_CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output side: random stalls, one long hold once traffic is going
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && sb.words_in >= 150) begin
            i_out_ready <= 1'b0;
            hold_left   <= 80;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= burst || ($urandom_range(99) >= C_IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_word({o_word_out, o_error_found, o_error_position, o_uncorrectable});
        end
    end

    function automatic t_word rand_word();
        return t_word'({$urandom(), $urandom()});
    endfunction

    task automatic send_word(t_op op, t_word w);
        while (!burst && $urandom_range(99) < C_IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_word_in   <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(op, w);
    endtask

    // decode a valid codeword, optionally with one flipped position and junk above n
    task automatic send_coded(t_word data, int flip, t_word junk);
        t_hc_result enc;
        t_word      mask;
        enc  = sb.predict(OP_ENCODE, data);
        mask = (t_word'(1) << sb.code_len()) - t_word'(1);
        if (flip != 0) enc.word[flip-1] = ~enc.word[flip-1];
        send_word(OP_DECODE, enc.word | (junk & ~mask));
    endtask

    task automatic send_random();
        int    sel;
        int    n;
        t_word junk;
        n    = sb.code_len();
        sel  = $urandom_range(99);
        junk = ($urandom_range(3) == 0) ? rand_word() : '0;
        if (sel < 35) begin
            send_word(OP_ENCODE, rand_word());
        end else if (sel < 85) begin
            send_coded(rand_word(), ($urandom_range(3) == 0) ? 0 : $urandom_range(n, 1), junk);
        end else begin
            send_word(OP_DECODE, rand_word());
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(t_len v);
        i_cfg_valid       <= 1'b1;
        i_cfg_data_length <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.data_len = v;
    endtask

    initial begin
        int lengths[10];
        lengths = '{1, 0, 2, 4, 63, 58, 26, 5, 33, 11};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset length: k = 4, n = 7
        send_word(OP_ENCODE, '1);
        send_word(OP_DECODE, '1);
        send_coded(t_word'(4'hA), 7, '0);
        drain();

        // k = 10, n = 14: syndromes up to 15 can point past the word
        write_length(t_len'(10));
        send_word(OP_ENCODE, '0);
        send_word(OP_ENCODE, '1);
        send_word(OP_ENCODE, t_word'(1));
        send_word(OP_ENCODE, t_word'(1) << 9);
        send_word(OP_DECODE, '0);
        send_word(OP_DECODE, '1);
        send_coded('1, 0, '0);
        send_coded('1, 1, '0);
        send_coded(t_word'(10'h155), 8, '0);
        send_coded(t_word'(10'h2AA), 14, '0);
        send_word(OP_DECODE, t_word'(14'h2001));
        send_coded(t_word'(10'h0F0), 0, '1);
        drain();

        // k = 57, n = 63: full width
        write_length(t_len'(C_MAX_DATA_BITS));
        send_word(OP_ENCODE, '1);
        send_word(OP_DECODE, '1);
        send_coded(rand_word(), 63, '0);
        send_coded(rand_word(), 32, '0);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            write_length(t_len'((ph < 10) ? lengths[ph] : $urandom_range(63)));
            burst = (ph == 2);
            for (int i = 0; i < C_WORDS_PER_PHASE; i++) begin
                send_random();
            end
            drain();
        end
        burst = 1'b0;

        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
